[design/owm_pkg.sv]
// Shared types, constants and the arctangent table for the odometry waypoint navigator.
`default_nettype none

package owm_pkg;

  // Fixed-point constants
  localparam logic [37:0] INV2PI_Q40 = 38'd174992710647;
  localparam logic [38:0] INV2PI_X2  = 39'd349985421294;
  localparam logic [26:0] TWOPI_Q24  = 27'd105414357;
  localparam logic [29:0] CORDIC_K   = 30'd652032875;
  localparam int          CordicSteps = 30;

  // Register reset values
  localparam logic [20:0] WHEEL_BASE_RST = 21'd55574;
  localparam logic [15:0] POS_TOL_RST    = 16'd10486;
  localparam logic [13:0] DIR_TOL_RST    = 14'd521;
  localparam logic [9:0]  TURN_SPD_RST   = 10'd100;
  localparam logic [9:0]  FWD_SPD_RST    = 10'd300;
  localparam logic [31:0] TARGET_X_RST   = 32'd629146;
  localparam logic [31:0] TARGET_Y_RST   = 32'd2673869;

  // Divider bit counts
  localparam logic [6:0] DIV_CNT_T    = 7'd62;
  localparam logic [6:0] DIV_CNT_POLY = 7'd30;
  localparam logic [6:0] DIV_CNT_SINC = 7'd63;

  typedef enum logic [2:0] {
    CFG_WHEEL_BASE = 3'd0,
    CFG_POS_TOL    = 3'd1,
    CFG_DIR_TOL    = 3'd2,
    CFG_TURN_SPEED = 3'd3,
    CFG_FWD_SPEED  = 3'd4,
    CFG_TARGET_X   = 3'd5,
    CFG_TARGET_Y   = 3'd6
  } cfg_idx_t;

  typedef enum logic {
    MD_MUL,
    MD_DIV
  } md_op_t;

  typedef enum logic {
    CD_ROT,
    CD_VEC
  } cd_mode_t;

  typedef struct packed {
    logic       start;
    md_op_t     op;
    logic [6:0] cnt;
  } md_req_t;

  typedef struct packed {
    logic     start;
    cd_mode_t mode;
  } cd_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_TMUL,
    S_TDIV,
    S_XMUL,
    S_X2,
    S_X4,
    S_X6,
    S_D2,
    S_D4,
    S_D6,
    S_SROT,
    S_SMUL,
    S_SDIV,
    S_UMUL,
    S_DROT,
    S_DXMUL,
    S_DYMUL,
    S_CTRL,
    S_VEC,
    S_OUT
  } state_t;

  // atan(2^-i) in Q32 circles
  function automatic logic [29:0] atan_lut(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[design/owm_muldiv.sv]
// Bit-serial unsigned multiplier and restoring divider, one bit per cycle.
`default_nettype none

module owm_muldiv (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire owm_pkg::md_req_t req,
  input  wire logic [63:0]     a_i,
  input  wire logic [63:0]     b_i,
  output logic                 done_o,
  output logic [63:0]          res_o
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  owm_pkg::md_op_t   op_r, op_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic [63:0]       a_r, a_nxt;
  logic [63:0]       b_r, b_nxt;
  logic [63:0]       rem_r, rem_nxt;
  logic [6:0]        cnt_r, cnt_nxt;

  // Step logic: multiplier bits LSB first, dividend bits MSB first
  always_comb begin
    logic [64:0] rem_sh;
    logic [6:0]  shamt;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    rem_sh   = {rem_r, b_r[63]};
    shamt    = 7'd64 - req.cnt;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      acc_nxt  = '0;
      a_nxt    = a_i;
      b_nxt    = (req.op == owm_pkg::MD_DIV) ? (b_i << shamt) : b_i;
      rem_nxt  = '0;
      cnt_nxt  = req.cnt;
    end else if (busy_r) begin
      if (op_r == owm_pkg::MD_MUL) begin
        if (b_r == '0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          if (b_r[0]) acc_nxt = acc_r + a_r;
          a_nxt = {a_r[62:0], 1'b0};
          b_nxt = {1'b0, b_r[63:1]};
        end
      end else begin
        if (rem_sh >= {1'b0, a_r}) begin
          rem_nxt = 64'(rem_sh - {1'b0, a_r});
          b_nxt   = {b_r[62:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[63:0];
          b_nxt   = {b_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done_o = done_r;
  assign res_o  = (op_r == owm_pkg::MD_DIV) ? b_r : acc_r;

endmodule

`default_nettype wire

[design/owm_cordic.sv]
// Iterative CORDIC, one micro-rotation per cycle, rotation and vectoring modes.
`default_nettype none

module owm_cordic (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire owm_pkg::cd_req_t req,
  input  wire logic [31:0]      ang_i,
  input  wire logic signed [32:0] vx_i,
  input  wire logic signed [32:0] vy_i,
  output logic                  done_o,
  output logic signed [32:0]    cos_o,
  output logic signed [32:0]    sin_o,
  output logic [31:0]           ang_o
);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  owm_pkg::cd_mode_t   mode_r, mode_nxt;
  logic                neg_r, neg_nxt;
  logic signed [35:0]  x_r, x_nxt;
  logic signed [35:0]  y_r, y_nxt;
  logic signed [33:0]  z_r, z_nxt;
  logic [4:0]          i_r, i_nxt;

  // Start-up fold and one micro-rotation per cycle
  always_comb begin
    logic [31:0]        a_off;
    logic [31:0]        a_f;
    logic signed [35:0] sx, sy, vx_e, vy_e;
    logic signed [33:0] at;
    logic               dir;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    mode_nxt = mode_r;
    neg_nxt  = neg_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    i_nxt    = i_r;
    a_off    = ang_i - 32'h4000_0000;
    a_f      = a_off[31] ? ang_i : (ang_i ^ 32'h8000_0000);
    vx_e     = 36'(vx_i);
    vy_e     = 36'(vy_i);
    sx       = x_r >>> i_r;
    sy       = y_r >>> i_r;
    at       = 34'(owm_pkg::atan_lut(i_r));
    dir      = (mode_r == owm_pkg::CD_ROT) ? !z_r[33] : y_r[35];
    if (req.start) begin
      busy_nxt = 1'b1;
      mode_nxt = req.mode;
      i_nxt    = '0;
      if (req.mode == owm_pkg::CD_ROT) begin
        neg_nxt = !a_off[31];
        x_nxt   = 36'(owm_pkg::CORDIC_K);
        y_nxt   = '0;
        z_nxt   = 34'($signed(a_f));
      end else begin
        neg_nxt = 1'b0;
        x_nxt   = vx_i[32] ? -vx_e : vx_e;
        y_nxt   = vx_i[32] ? -vy_e : vy_e;
        z_nxt   = vx_i[32] ? 34'sh0_8000_0000 : 34'sd0;
      end
    end else if (busy_r) begin
      if (dir) begin
        x_nxt = x_r - sy;
        y_nxt = y_r + sx;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + sy;
        y_nxt = y_r - sx;
        z_nxt = z_r + at;
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(owm_pkg::CordicSteps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    neg_r  <= neg_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    i_r    <= i_nxt;
  end

  // Undo the half-turn fold
  always_comb begin
    logic signed [35:0] xo, yo;
    xo    = neg_r ? -x_r : x_r;
    yo    = neg_r ? -y_r : y_r;
    cos_o = xo[32:0];
    sin_o = yo[32:0];
  end

  assign done_o = done_r;
  assign ang_o  = z_r[31:0];

endmodule

`default_nettype wire

[design/odometry_waypoint_navigator.sv]
// Odometry waypoint navigator top level: sequencer, state and channel registers.
//
//  channel  | ports                               | handshake
//  ---------+-------------------------------------+-----------------------------
//  input    | in_left_travel, in_right_travel     | in_valid / in_stall
//  result   | out_left_speed .. out_heading       | out_valid / out_stall
//  config   | cfg_index, cfg_data                 | cfg_we, no wait
//
// One item runs as a chain of serial operations: every multiply steps through
// the multiplier bits up to its top set bit, divides produce 62, 30 or 63
// quotient bits, each CORDIC pass makes 30 micro-rotations, and each operation
// adds a launch step. Items are worked one at a time.
// Reset loads the register defaults and clears pose, route step and held speeds.
// A result waiting under out_stall does not block the next input transfer.
`default_nettype none

module odometry_waypoint_navigator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [23:0] in_left_travel,
  input  wire logic signed [23:0] in_right_travel,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [10:0]      out_left_speed,
  output logic signed [10:0]      out_right_speed,
  output logic [1:0]              out_waypoint_index,
  output logic                    out_route_done,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic [15:0]             out_heading,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  // Configuration registers
  logic [20:0] wheel_base_r;
  logic [15:0] pos_tol_r;
  logic [13:0] dir_tol_r;
  logic [9:0]  turn_spd_r;
  logic [9:0]  fwd_spd_r;
  logic [31:0] target_x_r;
  logic [31:0] target_y_r;

  // Navigation state
  logic signed [31:0] est_x_r;
  logic signed [31:0] est_y_r;
  logic [15:0]        est_heading_r;
  logic [1:0]         step_r;
  logic signed [10:0] held_l_r;
  logic signed [10:0] held_r_r;
  logic               done_r;

  // Per-item working registers
  logic [23:0] absd_r;
  logic        dneg_r;
  logic [24:0] summ_r;
  logic        sumneg_r;
  logic [62:0] wide_r;
  logic [61:0] t_r;
  logic [28:0] x_r, x2_r, x4_r;
  logic [30:0] poly_r;
  logic [26:0] s24m_r;
  logic [25:0] sincm_r;
  logic        sincneg_r;
  logic [25:0] um_r;
  logic        un_r;

  owm_pkg::state_t state_r, state_nxt;
  logic            run_r;

  // Unit requests and results
  owm_pkg::md_req_t   md_req;
  logic [63:0]        md_a, md_b, md_res;
  logic               md_done;
  owm_pkg::cd_req_t   cd_req;
  logic [31:0]        cd_ang_in, cd_ang;
  logic signed [32:0] cd_vx, cd_vy, cd_cos, cd_sin;
  logic               cd_done;
  logic               md_state, cd_state, op_done, op_start;

  logic               in_xfer, out_load;
  logic [20:0]        wb_eff;
  logic [31:0]        half_v, dir_ang;
  logic [15:0]        dth_v;
  logic signed [33:0] ex, ey;
  logic [33:0]        ex_m, ey_m;
  logic               reach;
  logic [30:0]        cmag, smag;
  logic               out_valid_r;

  owm_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (md_req),
    .a_i    (md_a),
    .b_i    (md_b),
    .done_o (md_done),
    .res_o  (md_res)
  );

  owm_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (cd_req),
    .ang_i  (cd_ang_in),
    .vx_i   (cd_vx),
    .vy_i   (cd_vy),
    .done_o (cd_done),
    .cos_o  (cd_cos),
    .sin_o  (cd_sin),
    .ang_o  (cd_ang)
  );

  // Derived values
  always_comb begin
    logic [40:0]        hsum;
    logic [39:0]        dsum;
    logic signed [32:0] c_s, s_s;
    wb_eff  = (wheel_base_r == '0) ? 21'd1 : wheel_base_r;
    hsum    = t_r[40:0] + 41'd256;
    dsum    = t_r[39:0] + 40'h80_0000;
    half_v  = dneg_r ? -hsum[40:9] : hsum[40:9];
    dth_v   = dneg_r ? -dsum[39:24] : dsum[39:24];
    dir_ang = {est_heading_r, 16'h0000} + half_v;
    ex      = 34'($signed(target_x_r)) - 34'(est_x_r);
    ey      = ((step_r == 2'd0) ? 34'sd0 : 34'($signed(target_y_r))) - 34'(est_y_r);
    ex_m    = ex[33] ? 34'(-ex) : 34'(ex);
    ey_m    = ey[33] ? 34'(-ey) : 34'(ey);
    reach   = (ex_m <= 34'(pos_tol_r)) && (ey_m <= 34'(pos_tol_r));
    c_s     = cd_cos[32] ? -cd_cos : cd_cos;
    s_s     = cd_sin[32] ? -cd_sin : cd_sin;
    cmag    = c_s[30:0];
    smag    = s_s[30:0];
  end

  always_comb begin
    case (state_r)
      owm_pkg::S_TMUL, owm_pkg::S_TDIV, owm_pkg::S_XMUL, owm_pkg::S_X2,
      owm_pkg::S_X4, owm_pkg::S_X6, owm_pkg::S_D2, owm_pkg::S_D4,
      owm_pkg::S_D6, owm_pkg::S_SMUL, owm_pkg::S_SDIV, owm_pkg::S_UMUL,
      owm_pkg::S_DXMUL, owm_pkg::S_DYMUL: md_state = 1'b1;
      default: md_state = 1'b0;
    endcase
  end

  assign cd_state = (state_r == owm_pkg::S_SROT) || (state_r == owm_pkg::S_DROT) ||
                    (state_r == owm_pkg::S_VEC);
  assign op_start = (md_state || cd_state) && !run_r;
  assign op_done  = md_state ? md_done : (cd_state & cd_done);
  assign in_xfer  = in_valid && !in_stall;
  assign out_load = (state_r == owm_pkg::S_OUT) && (!out_valid_r || !out_stall);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      owm_pkg::S_IDLE:  if (in_valid) state_nxt = owm_pkg::S_TMUL;
      owm_pkg::S_TMUL:  if (op_done) state_nxt = owm_pkg::S_TDIV;
      owm_pkg::S_TDIV: begin
        if (op_done) begin
          state_nxt = (md_res[61:37] == '0) ? owm_pkg::S_XMUL : owm_pkg::S_SROT;
        end
      end
      owm_pkg::S_XMUL:  if (op_done) state_nxt = owm_pkg::S_X2;
      owm_pkg::S_X2:    if (op_done) state_nxt = owm_pkg::S_X4;
      owm_pkg::S_X4:    if (op_done) state_nxt = owm_pkg::S_X6;
      owm_pkg::S_X6:    if (op_done) state_nxt = owm_pkg::S_D2;
      owm_pkg::S_D2:    if (op_done) state_nxt = owm_pkg::S_D4;
      owm_pkg::S_D4:    if (op_done) state_nxt = owm_pkg::S_D6;
      owm_pkg::S_D6:    if (op_done) state_nxt = owm_pkg::S_UMUL;
      owm_pkg::S_SROT:  if (op_done) state_nxt = owm_pkg::S_SMUL;
      owm_pkg::S_SMUL:  if (op_done) state_nxt = owm_pkg::S_SDIV;
      owm_pkg::S_SDIV:  if (op_done) state_nxt = owm_pkg::S_UMUL;
      owm_pkg::S_UMUL:  if (op_done) state_nxt = owm_pkg::S_DROT;
      owm_pkg::S_DROT:  if (op_done) state_nxt = owm_pkg::S_DXMUL;
      owm_pkg::S_DXMUL: if (op_done) state_nxt = owm_pkg::S_DYMUL;
      owm_pkg::S_DYMUL: if (op_done) state_nxt = owm_pkg::S_CTRL;
      owm_pkg::S_CTRL: begin
        state_nxt = (step_r[1] || reach) ? owm_pkg::S_OUT : owm_pkg::S_VEC;
      end
      owm_pkg::S_VEC:   if (op_done) state_nxt = owm_pkg::S_OUT;
      owm_pkg::S_OUT:   if (out_load) state_nxt = owm_pkg::S_IDLE;
      default:          state_nxt = owm_pkg::S_IDLE;
    endcase
  end

  // Unit operands per state
  always_comb begin
    in_stall      = (state_r != owm_pkg::S_IDLE);
    md_req.start  = op_start && md_state;
    md_req.op     = owm_pkg::MD_MUL;
    md_req.cnt    = owm_pkg::DIV_CNT_POLY;
    md_a          = '0;
    md_b          = '0;
    cd_req.start  = op_start && cd_state;
    cd_req.mode   = owm_pkg::CD_ROT;
    cd_ang_in     = dir_ang;
    cd_vx         = ex[32:0];
    cd_vy         = ey[32:0];
    case (state_r)
      owm_pkg::S_TMUL: begin
        md_a = 64'(owm_pkg::INV2PI_Q40);
        md_b = 64'(absd_r);
      end
      owm_pkg::S_TDIV: begin
        md_req.op  = owm_pkg::MD_DIV;
        md_req.cnt = owm_pkg::DIV_CNT_T;
        md_a       = 64'(wb_eff);
        md_b       = 64'(wide_r);
      end
      owm_pkg::S_XMUL: begin
        md_a = 64'(owm_pkg::TWOPI_Q24);
        md_b = 64'(t_r);
      end
      owm_pkg::S_X2: begin
        md_a = 64'(x_r);
        md_b = 64'(x_r);
      end
      owm_pkg::S_X4: begin
        md_a = 64'(x2_r);
        md_b = 64'(x2_r);
      end
      owm_pkg::S_X6: begin
        md_a = 64'(x4_r);
        md_b = 64'(x2_r);
      end
      owm_pkg::S_D2: begin
        md_req.op = owm_pkg::MD_DIV;
        md_a      = 64'd6;
        md_b      = 64'(x2_r);
      end
      owm_pkg::S_D4: begin
        md_req.op = owm_pkg::MD_DIV;
        md_a      = 64'd120;
        md_b      = 64'(x4_r);
      end
      owm_pkg::S_D6: begin
        md_req.op = owm_pkg::MD_DIV;
        md_a      = 64'd5040;
        md_b      = 64'(wide_r);
      end
      owm_pkg::S_SROT: cd_ang_in = t_r[40:9];
      owm_pkg::S_SMUL: begin
        md_a = 64'(owm_pkg::INV2PI_X2);
        md_b = 64'(s24m_r);
      end
      owm_pkg::S_SDIV: begin
        md_req.op  = owm_pkg::MD_DIV;
        md_req.cnt = owm_pkg::DIV_CNT_SINC;
        md_a       = 64'(t_r);
        md_b       = 64'(wide_r);
      end
      owm_pkg::S_UMUL: begin
        md_a = 64'(summ_r);
        md_b = 64'(sincm_r);
      end
      owm_pkg::S_DXMUL: begin
        md_a = 64'(um_r);
        md_b = 64'(cmag);
      end
      owm_pkg::S_DYMUL: begin
        md_a = 64'(um_r);
        md_b = 64'(smag);
      end
      owm_pkg::S_VEC: cd_req.mode = owm_pkg::CD_VEC;
      default: ;
    endcase
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= owm_pkg::S_IDLE;
      run_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (op_start) run_r <= 1'b1;
      else if (op_done) run_r <= 1'b0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_base_r <= owm_pkg::WHEEL_BASE_RST;
      pos_tol_r    <= owm_pkg::POS_TOL_RST;
      dir_tol_r    <= owm_pkg::DIR_TOL_RST;
      turn_spd_r   <= owm_pkg::TURN_SPD_RST;
      fwd_spd_r    <= owm_pkg::FWD_SPD_RST;
      target_x_r   <= owm_pkg::TARGET_X_RST;
      target_y_r   <= owm_pkg::TARGET_Y_RST;
    end else if (cfg_we) begin
      case (owm_pkg::cfg_idx_t'(cfg_index))
        owm_pkg::CFG_WHEEL_BASE: wheel_base_r <= {1'b0, cfg_data[19:0]} |
                                                 {cfg_data[20], 20'h0};
        owm_pkg::CFG_POS_TOL:    pos_tol_r    <= cfg_data[15:0];
        owm_pkg::CFG_DIR_TOL:    dir_tol_r    <= cfg_data[13:0];
        owm_pkg::CFG_TURN_SPEED: turn_spd_r   <= cfg_data[9:0];
        owm_pkg::CFG_FWD_SPEED:  fwd_spd_r    <= cfg_data[9:0];
        owm_pkg::CFG_TARGET_X:   target_x_r   <= cfg_data;
        owm_pkg::CFG_TARGET_Y:   target_y_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Working registers, loaded on an input transfer and as each operation finishes
  always_ff @(posedge clk) begin
    logic signed [24:0] sum_s;
    logic signed [24:0] dif_s;
    logic signed [32:0] s24;
    sum_s = 25'(in_left_travel) + 25'(in_right_travel);
    dif_s = 25'(in_right_travel) - 25'(in_left_travel);
    s24   = cd_sin >>> 6;
    if (in_xfer) begin
      absd_r   <= dif_s[24] ? 24'(-dif_s) : dif_s[23:0];
      dneg_r   <= dif_s[24];
      summ_r   <= sum_s[24] ? 25'(-sum_s) : 25'(sum_s);
      sumneg_r <= sum_s[24];
    end
    if (op_done) begin
      case (state_r)
        owm_pkg::S_TMUL: wide_r <= md_res[62:0];
        owm_pkg::S_TDIV: t_r    <= md_res[61:0];
        owm_pkg::S_XMUL: x_r    <= md_res[63:35];
        owm_pkg::S_X2:   x2_r   <= md_res[58:30];
        owm_pkg::S_X4:   x4_r   <= md_res[58:30];
        owm_pkg::S_X6:   wide_r <= 63'(md_res[58:30]);
        owm_pkg::S_D2:   poly_r <= 31'h4000_0000 - 31'(md_res[28:0]);
        owm_pkg::S_D4:   poly_r <= poly_r + 31'(md_res[28:0]);
        owm_pkg::S_D6: begin
          sincm_r   <= 26'((poly_r - 31'(md_res[28:0])) >> 6);
          sincneg_r <= 1'b0;
        end
        owm_pkg::S_SROT: begin
          s24m_r    <= s24[32] ? 27'(-s24) : s24[26:0];
          sincneg_r <= s24[32];
        end
        owm_pkg::S_SMUL: wide_r  <= md_res[62:0];
        owm_pkg::S_SDIV: sincm_r <= md_res[25:0];
        owm_pkg::S_UMUL: begin
          um_r <= 26'((md_res + 64'h100_0000) >> 25);
          un_r <= sumneg_r ^ sincneg_r;
        end
        default: ;
      endcase
    end
  end

  // Pose update and route control
  always_ff @(posedge clk) begin
    logic [63:0]        rnd;
    logic signed [33:0] dlt, acc;
    logic signed [31:0] upd;
    logic [31:0]        err_u;
    logic signed [32:0] err, tol;
    rnd   = (md_res + 64'h2000_0000) >> 30;
    dlt   = 34'(rnd[26:0]);
    if (state_r == owm_pkg::S_DXMUL) begin
      if (un_r ^ cd_cos[32]) dlt = -dlt;
      acc = 34'(est_x_r) + dlt;
    end else begin
      if (un_r ^ cd_sin[32]) dlt = -dlt;
      acc = 34'(est_y_r) + dlt;
    end
    if (acc > 34'sh0_7FFF_FFFF) upd = 32'sh7FFF_FFFF;
    else if (acc < -34'sh0_8000_0000) upd = 32'sh8000_0000;
    else upd = acc[31:0];
    err_u = cd_ang - {est_heading_r, 16'h0000};
    err   = 33'($signed(err_u));
    tol   = 33'({dir_tol_r, 16'h0000});
    if (!rst_n) begin
      est_x_r       <= '0;
      est_y_r       <= '0;
      est_heading_r <= '0;
      step_r        <= '0;
      held_l_r      <= '0;
      held_r_r      <= '0;
      done_r        <= 1'b0;
    end else begin
      if (op_done && state_r == owm_pkg::S_DXMUL) est_x_r <= upd;
      if (op_done && state_r == owm_pkg::S_DYMUL) begin
        est_y_r       <= upd;
        est_heading_r <= est_heading_r + dth_v;
      end
      if (state_r == owm_pkg::S_CTRL) begin
        done_r <= step_r[1];
        if (step_r[1]) begin
          held_l_r <= '0;
          held_r_r <= '0;
        end else if (reach) begin
          step_r <= step_r + 2'd1;
        end
      end
      if (op_done && state_r == owm_pkg::S_VEC) begin
        if (err > tol) begin
          held_l_r <= -$signed({1'b0, turn_spd_r});
          held_r_r <= $signed({1'b0, turn_spd_r});
        end else if (err < -tol) begin
          held_l_r <= $signed({1'b0, turn_spd_r});
          held_r_r <= -$signed({1'b0, turn_spd_r});
        end else begin
          held_l_r <= $signed({1'b0, fwd_spd_r});
          held_r_r <= $signed({1'b0, fwd_spd_r});
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_speed     <= held_l_r;
      out_right_speed    <= held_r_r;
      out_waypoint_index <= step_r;
      out_route_done     <= done_r;
      out_pos_x          <= est_x_r;
      out_pos_y          <= est_y_r;
      out_heading        <= est_heading_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_md_done_in_md_state: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> md_state) else $error("multiply/divide finished outside its step");
  a_cd_done_in_cd_state: assert property (@(posedge clk) disable iff (!rst_n)
    cd_done |-> cd_state) else $error("cordic finished outside its step");
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != 2'd3) else $error("route step out of range");
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == owm_pkg::S_TMUL) else $error("transfer did not start work");
`endif

endmodule

`default_nettype wire
